@@ hw/rtl/pinned_clock_replacement_table_assert.svh @@
// Assertion macros for the checker file of the table block.
// No dependencies; include by bare file name.
`ifndef PINNED_CLOCK_REPLACEMENT_TABLE_ASSERT_SVH
`define PINNED_CLOCK_REPLACEMENT_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCRT_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("pcrt assertion failed");

// Next-cycle implication, checked outside reset.
`define PCRT_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("pcrt assertion failed");

`endif

@@ hw/rtl/pcrt_pkg.sv @@
// Shared types, codes and constants of the pinned clock replacement table.
// No dependencies.
package pcrt_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int CFG_IW        = 2;
  localparam int CFG_DW        = 5;
  localparam int LIMIT_W       = 5;
  localparam int CHANCE_W      = 4;
  localparam logic [LIMIT_W-1:0]  OPEN_LIMIT_RST     = 5'd16;
  localparam logic [CHANCE_W-1:0] SECOND_CHANCES_RST = 4'd3;

  localparam logic [CFG_IW-1:0] CFG_OPEN_LIMIT     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SECOND_CHANCES = 2'd1;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_UNPIN  = 3'd2,
    CMD_EVICT  = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_ALL_PINNED = 2'd2,
    ST_BUSY       = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EX,
    S_CLK_INIT,
    S_CLK_RD,
    S_CLK_EX,
    S_COMP_RD,
    S_COMP_WR,
    S_INS,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]          key_type;
    logic [31:0]         key_file;
    logic [15:0]         handle;
    logic                pinned;
    logic [CHANCE_W-1:0] chances;
  } entry_t;

  typedef struct packed {
    st_t         status;
    logic [15:0] found_handle;
    logic        closed_valid;
    logic [7:0]  closed_type;
    logic [31:0] closed_file;
    logic [15:0] closed_handle;
    logic        last;
  } res_t;

  function automatic res_t final_res(st_t st, logic [15:0] found);
    res_t r;
    r = '0;
    r.status       = st;
    r.found_handle = found;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic res_t removal_res(entry_t e);
    res_t r;
    r = '0;
    r.closed_valid  = 1'b1;
    r.closed_type   = e.key_type;
    r.closed_file   = e.key_file;
    r.closed_handle = e.handle;
    return r;
  endfunction

endpackage

@@ hw/rtl/pcrt_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on pcrt_pkg for the entry type.
module pcrt_mem #(
  parameter int DEPTH = pcrt_pkg::ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pcrt_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output pcrt_pkg::entry_t rdata
);

  pcrt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pcrt_ctrl.sv @@
// Command sequencer: scans, clock sweep, compaction and insertion over the entry store.
// Depends on pcrt_pkg and instantiates pcrt_mem.
module pcrt_ctrl #(
  parameter int ENTRIES = pcrt_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [2:0]                    cmd_in,
  input  logic [7:0]                    type_in,
  input  logic [31:0]                   file_in,
  input  logic [15:0]                   handle_in,
  input  logic [pcrt_pkg::LIMIT_W-1:0]  open_limit,
  input  logic [pcrt_pkg::CHANCE_W-1:0] second_chances,
  input  logic                          slot_free,
  output logic                          idle,
  output logic                          push,
  output pcrt_pkg::res_t                res
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > pcrt_pkg::LIMIT_W) ? CW : pcrt_pkg::LIMIT_W;
  localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
  localparam logic [LW-1:0] ENT_L = LW'(ENTRIES);

  pcrt_pkg::state_t state, state_next, ret;
  pcrt_pkg::cmd_t   cmd;
  logic [7:0]       key_type;
  logic [31:0]      key_file;
  logic [15:0]      key_handle;
  logic [CW-1:0]    oc, cp, scan, idx, k;
  logic             changed;
  pcrt_pkg::res_t   pend;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  pcrt_pkg::entry_t wdata, rdata;

  logic [CW-1:0] scan_m1, idx_inc, k_p1;
  logic [LW-1:0] lim;
  logic          at_limit, key_hit, scan_take, victim, sweep_done;

  pcrt_mem #(.DEPTH(ENTRIES), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign scan_m1    = CW'(scan - 1'b1);
  assign k_p1       = CW'(k + 1'b1);
  assign idx_inc    = (CW'(idx + 1'b1) == oc) ? '0 : CW'(idx + 1'b1);
  assign lim        = (LW'(open_limit) < ENT_L) ? LW'(open_limit) : ENT_L;
  assign at_limit   = LW'(oc) >= lim;
  assign key_hit    = (rdata.key_type == key_type) && (rdata.key_file == key_file);
  assign victim     = !rdata.pinned && (rdata.chances == '0);
  assign sweep_done = (k == oc);
  assign idle       = (state == pcrt_pkg::S_IDLE);
  assign res        = pend;

  always_comb begin
    case (cmd)
      pcrt_pkg::CMD_LOOKUP: scan_take = key_hit && !rdata.pinned;
      pcrt_pkg::CMD_UNPIN:  scan_take = key_hit && (rdata.handle == key_handle);
      pcrt_pkg::CMD_CLOSE:  scan_take = key_hit;
      default:              scan_take = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pcrt_pkg::S_IDLE: begin
        if (in_fire) begin
          case (pcrt_pkg::cmd_t'(cmd_in))
            pcrt_pkg::CMD_LOOKUP, pcrt_pkg::CMD_UNPIN, pcrt_pkg::CMD_CLOSE:
              state_next = pcrt_pkg::S_SCAN_RD;
            pcrt_pkg::CMD_INSERT:
              state_next = at_limit ? pcrt_pkg::S_CLK_INIT : pcrt_pkg::S_INS;
            pcrt_pkg::CMD_EVICT: state_next = pcrt_pkg::S_CLK_INIT;
            default:             state_next = pcrt_pkg::S_EMIT;
          endcase
        end
      end
      pcrt_pkg::S_SCAN_RD:
        state_next = (scan == '0) ? pcrt_pkg::S_EMIT : pcrt_pkg::S_SCAN_EX;
      pcrt_pkg::S_SCAN_EX:
        state_next = scan_take ? pcrt_pkg::S_EMIT : pcrt_pkg::S_SCAN_RD;
      pcrt_pkg::S_CLK_INIT: begin
        if (oc == '0)     state_next = pcrt_pkg::S_EMIT;
        else if (cp > oc) state_next = pcrt_pkg::S_CLK_INIT;
        else              state_next = pcrt_pkg::S_CLK_RD;
      end
      pcrt_pkg::S_CLK_RD: begin
        if (!sweep_done)  state_next = pcrt_pkg::S_CLK_EX;
        else if (changed) state_next = pcrt_pkg::S_CLK_RD;
        else              state_next = pcrt_pkg::S_EMIT;
      end
      pcrt_pkg::S_CLK_EX:
        state_next = victim ? pcrt_pkg::S_EMIT : pcrt_pkg::S_CLK_RD;
      pcrt_pkg::S_COMP_RD: begin
        if (k_p1 < oc) begin
          state_next = pcrt_pkg::S_COMP_WR;
        end else begin
          case (cmd)
            pcrt_pkg::CMD_CLOSE:  state_next = pcrt_pkg::S_SCAN_RD;
            pcrt_pkg::CMD_INSERT: state_next = pcrt_pkg::S_INS;
            default:              state_next = pcrt_pkg::S_EMIT;
          endcase
        end
      end
      pcrt_pkg::S_COMP_WR: state_next = pcrt_pkg::S_COMP_RD;
      pcrt_pkg::S_INS:     state_next = pcrt_pkg::S_EMIT;
      pcrt_pkg::S_EMIT:    state_next = slot_free ? ret : pcrt_pkg::S_EMIT;
      default:             state_next = pcrt_pkg::S_IDLE;
    endcase
  end

  // memory port and output push; writes and reads never target the same
  // cycle, so a read always sees the last write (interlocked by sequencing)
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    push  = 1'b0;
    case (state)
      pcrt_pkg::S_SCAN_RD: raddr = scan_m1[AW-1:0];
      pcrt_pkg::S_SCAN_EX: begin
        waddr = scan_m1[AW-1:0];
        if (scan_take && cmd == pcrt_pkg::CMD_LOOKUP) begin
          we           = 1'b1;
          wdata.pinned = 1'b1;
        end else if (scan_take && cmd == pcrt_pkg::CMD_UNPIN) begin
          we            = 1'b1;
          wdata.pinned  = 1'b0;
          wdata.chances = second_chances;
        end
      end
      pcrt_pkg::S_CLK_RD: raddr = idx[AW-1:0];
      pcrt_pkg::S_CLK_EX: begin
        waddr         = idx[AW-1:0];
        wdata.chances = rdata.chances - 1'b1;
        we            = !rdata.pinned && !victim;
      end
      pcrt_pkg::S_COMP_RD: raddr = k_p1[AW-1:0];
      pcrt_pkg::S_COMP_WR: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
      end
      pcrt_pkg::S_INS: begin
        we             = (oc < ENT_C);
        waddr          = oc[AW-1:0];
        wdata.key_type = key_type;
        wdata.key_file = key_file;
        wdata.handle   = key_handle;
        wdata.pinned   = 1'b1;
        wdata.chances  = '0;
      end
      pcrt_pkg::S_EMIT: push = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcrt_pkg::S_IDLE;
      oc    <= '0;
      cp    <= '0;
    end else begin
      state <= state_next;
      case (state)
        pcrt_pkg::S_IDLE: begin
          if (in_fire) begin
            cmd        <= pcrt_pkg::cmd_t'(cmd_in);
            key_type   <= type_in;
            key_file   <= file_in;
            key_handle <= handle_in;
            scan       <= oc;
            pend       <= pcrt_pkg::final_res(pcrt_pkg::ST_OK, '0);
            ret        <= pcrt_pkg::S_IDLE;
          end
        end
        pcrt_pkg::S_SCAN_RD: begin
          if (scan == '0) begin
            pend <= pcrt_pkg::final_res((cmd == pcrt_pkg::CMD_CLOSE) ?
                    pcrt_pkg::ST_OK : pcrt_pkg::ST_NOT_FOUND, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end
        end
        pcrt_pkg::S_SCAN_EX: begin
          if (!scan_take) begin
            scan <= scan_m1;
          end else if (cmd == pcrt_pkg::CMD_LOOKUP) begin
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_OK, rdata.handle);
            ret  <= pcrt_pkg::S_IDLE;
          end else if (cmd != pcrt_pkg::CMD_CLOSE) begin
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_OK, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end else if (rdata.pinned) begin
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_BUSY, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end else begin
            pend <= pcrt_pkg::removal_res(rdata);
            ret  <= pcrt_pkg::S_COMP_RD;
            k    <= scan_m1;
          end
        end
        pcrt_pkg::S_CLK_INIT: begin
          if (oc == '0) begin
            cp   <= '0;
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_ALL_PINNED, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end else if (cp > oc) begin
            cp <= CW'(cp - oc);
          end else begin
            idx     <= (cp == oc) ? '0 : cp;
            k       <= '0;
            changed <= 1'b0;
          end
        end
        pcrt_pkg::S_CLK_RD: begin
          if (sweep_done && changed) begin
            k       <= '0;
            changed <= 1'b0;
          end else if (sweep_done) begin
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_ALL_PINNED, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end
        end
        pcrt_pkg::S_CLK_EX: begin
          if (victim) begin
            cp   <= idx;
            k    <= idx;
            pend <= pcrt_pkg::removal_res(rdata);
            ret  <= pcrt_pkg::S_COMP_RD;
          end else begin
            if (!rdata.pinned) changed <= 1'b1;
            k   <= k_p1;
            idx <= idx_inc;
          end
        end
        pcrt_pkg::S_COMP_RD: begin
          if (k_p1 >= oc) begin
            oc <= CW'(oc - 1'b1);
            if (cmd == pcrt_pkg::CMD_CLOSE) scan <= scan_m1;
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_OK, '0);
            ret  <= pcrt_pkg::S_IDLE;
          end
        end
        pcrt_pkg::S_COMP_WR: k <= k_p1;
        pcrt_pkg::S_INS: begin
          if (oc < ENT_C) begin
            oc   <= CW'(oc + 1'b1);
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_OK, '0);
          end else begin
            pend <= pcrt_pkg::final_res(pcrt_pkg::ST_ALL_PINNED, '0);
          end
          ret <= pcrt_pkg::S_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/pinned_clock_replacement_table.sv @@
// Top level of the pinned clock replacement table: config registers,
// output word register. Depends on pcrt_pkg; instantiates pcrt_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command word: cmd, type_id,
//   file_number, handle. One command runs at a time; in_ready is high only
//   while the sequencer is idle.
//   Output channel (out_valid/out_ready) gives one word per removed entry
//   (closed_valid high) and then one final word with last high and status.
//   Config channel (cfg_valid/cfg_ready) writes open_limit (index 0) and
//   second_chances (index 1); always ready, write only while idle.
// Steps: each table entry a command reads passes a memory read step and an
//   examine step; each entry moved down when an entry is removed passes a
//   read step and a write step; each output word handed over takes an emit step.
//   A clock sweep reads up to ENTRIES entries per pass and may need up to
//   16 passes (one more than the largest count an entry can hold). The entry
//   memory has one read and one write port and a registered read.
// Reset: the table is empty, clock position zero, open_limit 16,
//   second_chances 3. Entry memory is not cleared; only slots below the
//   open count are ever used.
// Stall: a result word waits in the output register; the sequencer holds
//   in its emit step until the register is free, then advances.
module pinned_clock_replacement_table #(
  parameter int ENTRIES = pcrt_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  cmd,
  input  logic [7:0]                  type_id,
  input  logic [31:0]                 file_number,
  input  logic [15:0]                 handle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [15:0]                 found_handle,
  output logic                        closed_valid,
  output logic [7:0]                  closed_type,
  output logic [31:0]                 closed_file,
  output logic [15:0]                 closed_handle,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pcrt_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pcrt_pkg::CFG_DW-1:0] cfg_data
);

  logic [pcrt_pkg::LIMIT_W-1:0]  open_limit;
  logic [pcrt_pkg::CHANCE_W-1:0] second_chances;
  logic                          idle, push, slot_free;
  pcrt_pkg::res_t                res, out_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign slot_free = !out_valid || out_ready;

  // config registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      open_limit     <= pcrt_pkg::OPEN_LIMIT_RST;
      second_chances <= pcrt_pkg::SECOND_CHANCES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcrt_pkg::CFG_OPEN_LIMIT:     open_limit     <= cfg_data;
        pcrt_pkg::CFG_SECOND_CHANCES: second_chances <= cfg_data[pcrt_pkg::CHANCE_W-1:0];
        default: ;
      endcase
    end
  end

  pcrt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_valid && in_ready),
    .cmd_in        (cmd),
    .type_in       (type_id),
    .file_in       (file_number),
    .handle_in     (handle),
    .open_limit    (open_limit),
    .second_chances(second_chances),
    .slot_free     (slot_free),
    .idle          (idle),
    .push          (push),
    .res           (res)
  );

  // output word register: load on push, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_word <= res;
    end
  end

  assign status        = out_word.status;
  assign found_handle  = out_word.found_handle;
  assign closed_valid  = out_word.closed_valid;
  assign closed_type   = out_word.closed_type;
  assign closed_file   = out_word.closed_file;
  assign closed_handle = out_word.closed_handle;
  assign last          = out_word.last;

endmodule

@@ hw/rtl/pcrt_check.sv @@
// Port-level checker for the table block, bound to the top level.
// Depends on pcrt_pkg and the assertion macro header.
`include "pinned_clock_replacement_table_assert.svh"

module pcrt_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [2:0]                  cmd,
  input logic [7:0]                  type_id,
  input logic [31:0]                 file_number,
  input logic [15:0]                 handle,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [15:0]                 found_handle,
  input logic                        closed_valid,
  input logic [7:0]                  closed_type,
  input logic [31:0]                 closed_file,
  input logic [15:0]                 closed_handle,
  input logic                        last,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [pcrt_pkg::CFG_IW-1:0] cfg_index,
  input logic [pcrt_pkg::CFG_DW-1:0] cfg_data
);

  // a waiting word stays until taken
  `PCRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // removal words never close a command and carry no status
  `PCRT_ASSERT_NOW(a_removal_word, out_valid && closed_valid,
                   !last && status == pcrt_pkg::ST_OK && found_handle == '0)
  // a final word reports no removed entry
  `PCRT_ASSERT_NOW(a_final_word, out_valid && last, !closed_valid)
  // one command at a time: busy right after an accept
  `PCRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind pinned_clock_replacement_table pcrt_check u_check (.*);
